// File: rtl/absd_pkg.sv
package absd_pkg;

	localparam int BYTE_W    = 8;
	localparam int SMP_W     = 16;
	localparam int COEF_W    = 8;
	localparam int PROD_W    = SMP_W + COEF_W;
	localparam int ACC_W     = 20;
	localparam int COEF_FRAC = 6;
	localparam int POS_W     = 4;
	localparam int SHIFT_W   = 4;
	localparam int FILT_W    = 3;

	localparam logic [POS_W-1:0] POS_HEADER = POS_W'(0);
	localparam logic [POS_W-1:0] POS_FLAGS  = POS_W'(1);
	localparam logic [POS_W-1:0] POS_LAST   = POS_W'(15);

	localparam logic [SHIFT_W-1:0] SHIFT_MAX  = SHIFT_W'(12);
	localparam logic [SHIFT_W-1:0] SHIFT_OVER = SHIFT_W'(9);
	localparam logic [FILT_W-1:0]  FILT_MAX   = FILT_W'(4);

	localparam logic signed [ACC_W-1:0] ACC_SMP_MIN = ACC_W'(-32768);
	localparam logic signed [ACC_W-1:0] ACC_SMP_MAX = ACC_W'(32767);
	localparam logic signed [SMP_W-1:0] SMP_MIN     = SMP_W'(-32768);
	localparam logic signed [SMP_W-1:0] SMP_MAX     = SMP_W'(32767);

	typedef struct packed {
		logic signed [SMP_W-1:0]  sample;
		logic signed [COEF_W-1:0] coef;
		logic signed [ACC_W-1:0]  addend;
	} mac_op_t;

	function automatic logic signed [COEF_W-1:0] coef_pos(input logic [FILT_W-1:0] f);
		case (f)
			3'd0:    coef_pos = COEF_W'(0);
			3'd1:    coef_pos = COEF_W'(60);
			3'd2:    coef_pos = COEF_W'(115);
			3'd3:    coef_pos = COEF_W'(98);
			default: coef_pos = COEF_W'(122);
		endcase
	endfunction

	function automatic logic signed [COEF_W-1:0] coef_neg(input logic [FILT_W-1:0] f);
		case (f)
			3'd0:    coef_neg = COEF_W'(0);
			3'd1:    coef_neg = COEF_W'(0);
			3'd2:    coef_neg = COEF_W'(-52);
			3'd3:    coef_neg = COEF_W'(-55);
			default: coef_neg = COEF_W'(-60);
		endcase
	endfunction

	function automatic logic signed [SMP_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
		if (v < ACC_SMP_MIN)
			sat16 = SMP_MIN;
		else if (v > ACC_SMP_MAX)
			sat16 = SMP_MAX;
		else
			sat16 = v[SMP_W-1:0];
	endfunction

endpackage

// File: rtl/absd_byte_if.sv
interface absd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

// File: rtl/absd_sample_if.sv
interface absd_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_first;
	logic signed [15:0] sample_second;
	logic [7:0]         block_flags;
	logic               last_in_block;

	modport source (output valid, output sample_first, output sample_second,
		output block_flags, output last_in_block, input ready);
	modport sink   (input valid, input sample_first, input sample_second,
		input block_flags, input last_in_block, output ready);
endinterface

// File: rtl/adpcm_block_sample_decoder.sv
// ADPCM block sample decoder.
// Feed the 16-byte blocks on "bytes", one byte per word: header byte (shift
// and filter), flags byte, then 14 data bytes. Blocks follow each other with
// no gap; the byte position wraps from 15 to 0.
// Header and flags bytes are only stored and give no result.
// Each data byte gives one word on "samples": the low-nibble sample, the
// high-nibble sample, the flags of the current block and a last-in-block mark.
// A data byte runs four passes through one shared multiply-add unit (newest
// and older history taps for each nibble), then the output register is loaded
// in ST_DONE; a new byte is accepted only after that load, since bytes.ready
// is high only in ST_IDLE.
// If the receiver stalls, the result is held in the output register; the
// next byte is still accepted and decoded, and the block holds before loading
// its result until the output register is free, with bytes.ready low.
// Reset clears the byte position, the history, the shift, the filter and the
// flags to zero, and leaves no result pending.
module adpcm_block_sample_decoder (
	input  logic          clk,
	input  logic          arst_n,
	absd_byte_if.sink     bytes,
	absd_sample_if.source samples
);
	import absd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRED_NEW,
		ST_PRED_OLD,
		ST_DONE
	} state_t;

	state_t                   state_q;
	logic [POS_W-1:0]         pos_q;
	logic signed [SMP_W-1:0]  hist_new_q;
	logic signed [SMP_W-1:0]  hist_old_q;
	logic [SHIFT_W-1:0]       shift_q;
	logic [FILT_W-1:0]        filter_q;
	logic [BYTE_W-1:0]        flags_q;
	logic [BYTE_W-1:0]        byte_q;
	logic                     nib_hi_q;
	logic                     last_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [SMP_W-1:0]  first_q;
	logic signed [SMP_W-1:0]  second_q;

	logic                     out_valid_q;
	logic signed [SMP_W-1:0]  out_first_q;
	logic signed [SMP_W-1:0]  out_second_q;
	logic [BYTE_W-1:0]        out_flags_q;
	logic                     out_last_q;

	logic [3:0]               hdr_shift;
	logic [FILT_W-1:0]        hdr_filt;
	logic signed [3:0]        nib;
	logic signed [ACC_W-1:0]  nib_ext;
	mac_op_t                  op;
	logic signed [ACC_W-1:0]  sum;
	logic signed [SMP_W-1:0]  sat;
	logic                     out_load;

	assign hdr_shift = bytes.data_byte[3:0];
	assign hdr_filt  = bytes.data_byte[6:4];
	assign nib       = nib_hi_q ? byte_q[7:4] : byte_q[3:0];
	assign nib_ext   = ACC_W'(nib);

	always_comb begin
		if (state_q == ST_PRED_OLD) begin
			op.sample = hist_old_q;
			op.coef   = coef_neg(filter_q);
			op.addend = acc_q;
		end else begin
			op.sample = hist_new_q;
			op.coef   = coef_pos(filter_q);
			op.addend = nib_ext <<< shift_q;
		end
	end

	absd_mac u_mac (
		.op  (op),
		.sum (sum)
	);

	assign sat = sat16(sum);

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || samples.ready);

	assign bytes.ready           = (state_q == ST_IDLE);
	assign samples.valid         = out_valid_q;
	assign samples.sample_first  = out_first_q;
	assign samples.sample_second = out_second_q;
	assign samples.block_flags   = out_flags_q;
	assign samples.last_in_block = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			hist_new_q  <= '0;
			hist_old_q  <= '0;
			shift_q     <= '0;
			filter_q    <= '0;
			flags_q     <= '0;
			nib_hi_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (samples.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (bytes.valid) begin
						pos_q <= pos_q + POS_W'(1);
						if (pos_q == POS_HEADER) begin
							shift_q  <= (hdr_shift > SHIFT_MAX) ? SHIFT_OVER
								: SHIFT_MAX - hdr_shift;
							filter_q <= (hdr_filt > FILT_MAX) ? FILT_MAX : hdr_filt;
						end else if (pos_q == POS_FLAGS) begin
							flags_q <= bytes.data_byte;
						end else begin
							byte_q   <= bytes.data_byte;
							last_q   <= (pos_q == POS_LAST);
							nib_hi_q <= 1'b0;
							state_q  <= ST_PRED_NEW;
						end
					end
				end
				ST_PRED_NEW: begin
					acc_q   <= sum;
					state_q <= ST_PRED_OLD;
				end
				ST_PRED_OLD: begin
					hist_old_q <= hist_new_q;
					hist_new_q <= sat;
					if (!nib_hi_q) begin
						first_q  <= sat;
						nib_hi_q <= 1'b1;
						state_q  <= ST_PRED_NEW;
					end else begin
						second_q <= sat;
						state_q  <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						out_first_q  <= first_q;
						out_second_q <= second_q;
						out_flags_q  <= flags_q;
						out_last_q   <= last_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/absd_mac.sv
module absd_mac (
	input  absd_pkg::mac_op_t                  op,
	output logic signed [absd_pkg::ACC_W-1:0]  sum
);
	import absd_pkg::*;

	logic signed [PROD_W-1:0] prod;

	assign prod = op.sample * op.coef;
	assign sum  = op.addend + ACC_W'(prod >>> COEF_FRAC);
endmodule

// File: tb/sv/tb_adpcm_block_sample_decoder.sv
module tb_adpcm_block_sample_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import absd_pkg::*;

	localparam int DRAIN_MARK  = -1;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 300;
	localparam int TAIL_CYCLES = 12;

	typedef struct {
		logic signed [SMP_W-1:0] first;
		logic signed [SMP_W-1:0] second;
		logic [BYTE_W-1:0]       flags;
		logic                    last;
	} sample_word_t;

	const int TAP_NEW[5] = '{0, 60, 115, 98, 122};
	const int TAP_OLD[5] = '{0, 0, -52, -55, -60};

	logic clk;
	logic arst_n;

	absd_byte_if   byte_bus ();
	absd_sample_if smp_bus ();

	adpcm_block_sample_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (byte_bus),
		.samples (smp_bus)
	);

	logic [POS_W-1:0]          at_pos;
	logic signed [SMP_W-1:0]   hist_new;
	logic signed [SMP_W-1:0]   hist_old;
	logic [SHIFT_W-1:0]        cur_shift;
	logic [FILT_W-1:0]         cur_filt;
	logic [BYTE_W-1:0]         cur_flags;

	int           byte_plan[$];
	sample_word_t pending_samples[$];
	int           errors;
	int           results_seen;
	int           cycles;

	int gap_left;
	int burst_left;
	int hold_left;
	bit long_hold_done;
	int ready_mode;
	int mode_left;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d, expected %0d (result %0d)", what, got, want,
			results_seen);
		errors++;
	endtask

	function automatic logic signed [SMP_W-1:0] decode_nibble(input logic [3:0] nib);
		int t;
		int acc;
		logic signed [SMP_W-1:0] s;
		t = nib[3] ? int'(nib) - 16 : int'(nib);
		acc = (t <<< cur_shift)
			+ ((int'(hist_new) * TAP_NEW[cur_filt]) >>> COEF_FRAC)
			+ ((int'(hist_old) * TAP_OLD[cur_filt]) >>> COEF_FRAC);
		if (acc < -32768)
			s = SMP_MIN;
		else if (acc > 32767)
			s = SMP_MAX;
		else
			s = acc[SMP_W-1:0];
		hist_old = hist_new;
		hist_new = s;
		return s;
	endfunction

	function automatic void predict_byte(input logic [BYTE_W-1:0] b);
		sample_word_t w;
		if (at_pos == POS_HEADER) begin
			cur_shift = (b[3:0] > SHIFT_MAX) ? SHIFT_OVER : SHIFT_MAX - b[3:0];
			cur_filt  = (b[6:4] > FILT_MAX) ? FILT_MAX : b[6:4];
		end else if (at_pos == POS_FLAGS) begin
			cur_flags = b;
		end else begin
			w.first  = decode_nibble(b[3:0]);
			w.second = decode_nibble(b[7:4]);
			w.flags  = cur_flags;
			w.last   = (at_pos == POS_LAST);
			pending_samples.push_back(w);
		end
		at_pos = at_pos + POS_W'(1);
	endfunction

	function automatic int pick_byte(input int idx);
		int sel;
		sel = $urandom_range(0, 3);
		if (idx % 16 == 0) begin
			if (sel == 0)
				return $urandom_range(0, 255);
			return ($urandom_range(0, 4) << 4) | $urandom_range(0, 12);
		end
		if (idx % 16 == 1 || sel != 0)
			return $urandom_range(0, 255);
		case ($urandom_range(0, 5))
			0: return 8'h77;
			1: return 8'h88;
			2: return 8'h7F;
			3: return 8'hF7;
			4: return 8'h08;
			default: return 8'h80;
		endcase
	endfunction

	initial begin
		int directed[$];
		int total;
		arst_n = 1'b0;
		byte_bus.valid = 1'b0;
		byte_bus.data_byte = '0;
		smp_bus.ready = 1'b0;
		at_pos = '0;
		hist_new = '0;
		hist_old = '0;
		cur_shift = '0;
		cur_filt = '0;
		cur_flags = '0;
		errors = 0;
		results_seen = 0;

		// clamped shift and filter, all nibble extremes, then saturating pulls
		directed = '{8'h7F, 8'hFF, 8'h77, 8'h77, 8'h88, 8'h88, 8'h00, 8'hFF, 8'h0F,
			8'hF0, 8'h80, 8'h08, 8'h7F, 8'hF7, 8'h12, 8'h34,
			8'h30, 8'h05, 8'h77, 8'h77, 8'h88, 8'h88};
		foreach (directed[i])
			byte_plan.push_back(directed[i]);
		byte_plan.push_back(DRAIN_MARK);
		total = directed.size();
		for (int i = 0; i < 400; i++) begin
			if (i == 240)
				byte_plan.push_back(DRAIN_MARK);
			byte_plan.push_back(pick_byte(total));
			total++;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_plan.size() != 0 || byte_bus.valid || pending_samples.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles,
				pending_samples.size());
			$display("FAILURE");
			$finish;
		end
	end

	initial cycles = 0;

	// sender: bursts with random gaps, hold at drain marks until all words return
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_bus.valid <= 1'b0;
			byte_bus.data_byte <= '0;
			gap_left <= 0;
			burst_left <= 8;
		end else if (!byte_bus.valid || byte_bus.ready) begin
			if (gap_left != 0) begin
				byte_bus.valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (byte_plan.size() == 0) begin
				byte_bus.valid <= 1'b0;
			end else if (byte_plan[0] == DRAIN_MARK) begin
				byte_bus.valid <= 1'b0;
				if (!byte_bus.valid && pending_samples.size() == 0)
					void'(byte_plan.pop_front());
			end else begin
				byte_bus.valid <= 1'b1;
				byte_bus.data_byte <= BYTE_W'(byte_plan.pop_front());
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// receiver: one long hold-off, otherwise a stall pattern that changes every stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_bus.ready <= 1'b0;
			hold_left <= 0;
			long_hold_done <= 1'b0;
			ready_mode <= 0;
			mode_left <= 0;
		end else if (hold_left != 0) begin
			smp_bus.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!long_hold_done && results_seen >= 40) begin
			smp_bus.ready <= 1'b0;
			hold_left <= LONG_HOLD;
			long_hold_done <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				ready_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(10, 80);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (ready_mode)
				0: smp_bus.ready <= 1'b1;
				1: smp_bus.ready <= 1'($urandom_range(0, 1));
				2: smp_bus.ready <= ($urandom_range(0, 4) == 0);
				default: smp_bus.ready <= cycles[1];
			endcase
		end
	end

	always @(posedge clk) begin
		sample_word_t want;
		if (arst_n) begin
			if (smp_bus.valid && smp_bus.ready) begin
				if (pending_samples.size() == 0) begin
					$display("unexpected sample word: first %0d second %0d",
						smp_bus.sample_first, smp_bus.sample_second);
					errors++;
				end else begin
					want = pending_samples.pop_front();
					if (smp_bus.sample_first !== want.first)
						report_mismatch("sample_first", int'(smp_bus.sample_first),
							int'(want.first));
					if (smp_bus.sample_second !== want.second)
						report_mismatch("sample_second", int'(smp_bus.sample_second),
							int'(want.second));
					if (smp_bus.block_flags !== want.flags)
						report_mismatch("block_flags", int'(smp_bus.block_flags),
							int'(want.flags));
					if (smp_bus.last_in_block !== want.last)
						report_mismatch("last_in_block", int'(smp_bus.last_in_block),
							int'(want.last));
				end
				results_seen++;
			end
			if (byte_bus.valid && byte_bus.ready)
				predict_byte(byte_bus.data_byte);
		end
	end

endmodule
